/* sv/pqg_pkg.sv */
// Package for the publisher quiesce gate: event codes, status codes, gate modes,
// register map and the request record. Used by every file of the block.
package pqg_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned AddrW  = 4;

  typedef enum logic [2:0] {
    OP_ENTER   = 3'd0,
    OP_EXIT    = 3'd1,
    OP_BEGIN   = 3'd2,
    OP_DEFER   = 3'd3,
    OP_FINISH  = 3'd4,
    OP_ABORT   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_BUSY     = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_STALE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    GM_OPEN     = 2'd0,
    GM_DRAINING = 2'd1,
    GM_QUIESCED = 2'd2
  } gate_mode_e;

  typedef enum logic {
    REG_GATE_OWNER  = 1'b0,
    REG_DEFERRABLE  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic             handle_active;
    logic [DataW-1:0] handle_owner;
    logic [DataW-1:0] handle_number;
    logic [DataW-1:0] defer_bit;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] gate_owner;
    logic [DataW-1:0] deferrable_events;
  } cfg_t;

endpackage

/* sv/pqg_if.sv */
// Stream interfaces for the publisher quiesce gate: request and result channels.
// Depends on pqg_pkg for field widths.
interface pqg_req_if
  import pqg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [2:0]       mode;
  logic             handle_active;
  logic [DataW-1:0] handle_owner;
  logic [DataW-1:0] handle_number;
  logic [DataW-1:0] defer_bit;

  modport source (output valid, mode, handle_active, handle_owner, handle_number,
                  defer_bit, input ready);
  modport sink (input valid, mode, handle_active, handle_owner, handle_number,
                defer_bit, output ready);
endinterface

interface pqg_rsp_if
  import pqg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [DataW-1:0]  issued_number;
  logic [DataW-1:0]  deferred_events;
  logic [1:0]        gate_state;
  logic [CountW-1:0] publisher_count;

  modport source (output valid, status, issued_number, deferred_events, gate_state,
                  publisher_count, input ready);
  modport sink (input valid, status, issued_number, deferred_events, gate_state,
                publisher_count, output ready);
endinterface

/* sv/pqg_apb_regs.sv */
// APB configuration registers of the publisher quiesce gate: owner and deferrable mask.
// Depends on pqg_pkg.
module pqg_apb_regs
  import pqg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_GATE_OWNER: cfg_d.gate_owner        = pwdata;
        REG_DEFERRABLE: cfg_d.deferrable_events = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GATE_OWNER: prdata = cfg_q.gate_owner;
      REG_DEFERRABLE: prdata = cfg_q.deferrable_events;
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/pqg_in_stage.sv */
// Input register of the publisher quiesce gate: holds one request transfer.
// Depends on pqg_pkg and pqg_req_if.
module pqg_in_stage
  import pqg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  pqg_req_if.sink req_i,
  input  logic  take_i,
  output logic  valid_o,
  output req_t  req_o
);

  logic valid_q, valid_d;
  req_t req_q;
  logic load;

  assign req_i.ready = !valid_q || take_i;
  assign load        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= '{mode:          req_i.mode,
                 handle_active: req_i.handle_active,
                 handle_owner:  req_i.handle_owner,
                 handle_number: req_i.handle_number,
                 defer_bit:     req_i.defer_bit};
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

/* sv/pqg_engine.sv */
// Gate state and event evaluation of the publisher quiesce gate, with the result register.
// Depends on pqg_pkg and pqg_rsp_if.
module pqg_engine
  import pqg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  input  req_t  req_i,
  output logic  take_o,
  pqg_rsp_if.source rsp_o
);

  gate_mode_e        mode_q, mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic [DataW-1:0]  gen_q, gen_d;
  logic [DataW-1:0]  last_q, last_d;
  logic [DataW-1:0]  cur_q, cur_d;
  logic [DataW-1:0]  mask_q, mask_d;

  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [DataW-1:0]  issued_q, issued_d;
  logic [DataW-1:0]  handed_q, handed_d;

  logic              advance;
  logic              consistent;
  logic              empty;
  logic              reopen_match;
  logic              idle_gen_full;
  op_e               op;
  logic [DataW-1:0]  bit_v;

  assign take_o  = !out_valid_q || rsp_o.ready;
  assign advance = valid_i && take_o;
  assign op      = op_e'(req_i.mode);
  assign bit_v   = req_i.defer_bit;

  always_comb begin
    consistent = 1'b0;
    if (cfg_i.gate_owner != '0 && gen_q != '0 && cur_q <= last_q) begin
      unique case (mode_q)
        GM_OPEN:     consistent = (cur_q == '0) && (mask_q == '0);
        GM_DRAINING: consistent = (cur_q != '0) && (count_q != '0);
        GM_QUIESCED: consistent = (cur_q != '0) && (count_q == '0);
        default:     consistent = 1'b0;
      endcase
    end
  end

  assign empty = !req_i.handle_active && (req_i.handle_owner == '0) &&
                 (req_i.handle_number == '0);
  assign reopen_match = req_i.handle_active && (req_i.handle_owner == cfg_i.gate_owner) &&
                        (req_i.handle_number == cur_q);
  assign idle_gen_full = (count_q == '0) && (gen_q == '1);

  always_comb begin
    mode_d   = mode_q;
    count_d  = count_q;
    gen_d    = gen_q;
    last_d   = last_q;
    cur_d    = cur_q;
    mask_d   = mask_q;
    status_d = ST_OK;
    issued_d = '0;
    handed_d = '0;
    if (!consistent) begin
      status_d = ST_INVALID;
    end else begin
      case (op)
        OP_ENTER: begin
          if (!empty || mode_q != GM_OPEN) begin
            status_d = ST_BUSY;
          end else if (count_q == '1) begin
            status_d = ST_OVERFLOW;
          end else begin
            issued_d = gen_q;
            count_d  = count_q + 1'b1;
          end
        end
        OP_EXIT: begin
          if (!req_i.handle_active || req_i.handle_owner != cfg_i.gate_owner ||
              req_i.handle_number != gen_q || count_q == '0) begin
            status_d = ST_STALE;
          end else begin
            count_d = count_q - 1'b1;
            if (mode_q == GM_DRAINING && count_q == CountW'(1)) begin
              mode_d = GM_QUIESCED;
            end
          end
        end
        OP_BEGIN: begin
          if (!empty || mode_q != GM_OPEN) begin
            status_d = ST_BUSY;
          end else if (last_q == '1) begin
            status_d = ST_OVERFLOW;
          end else begin
            last_d   = last_q + 1'b1;
            cur_d    = last_q + 1'b1;
            issued_d = last_q + 1'b1;
            mode_d   = (count_q == '0) ? GM_QUIESCED : GM_DRAINING;
          end
        end
        OP_DEFER: begin
          if (mode_q == GM_OPEN || bit_v == '0 || (bit_v & (bit_v - 1'b1)) != '0 ||
              (bit_v & ~cfg_i.deferrable_events) != '0) begin
            status_d = ST_INVALID;
          end else begin
            mask_d = mask_q | bit_v;
          end
        end
        OP_FINISH, OP_ABORT: begin
          if (!reopen_match) begin
            status_d = ST_STALE;
          end else if (op == OP_FINISH && mode_q != GM_QUIESCED) begin
            status_d = ST_BUSY;
          end else if (op == OP_ABORT && mode_q == GM_OPEN) begin
            status_d = ST_INVALID;
          end else if (idle_gen_full) begin
            status_d = ST_OVERFLOW;
          end else begin
            handed_d = mask_q;
            mask_d   = '0;
            cur_d    = '0;
            mode_d   = GM_OPEN;
            if (count_q == '0) begin
              gen_d = gen_q + 1'b1;
            end
          end
        end
        default: status_d = ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= GM_OPEN;
      count_q     <= '0;
      gen_q       <= DataW'(1);
      last_q      <= '0;
      cur_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        mode_q  <= mode_d;
        count_q <= count_d;
        gen_q   <= gen_d;
        last_q  <= last_d;
        cur_q   <= cur_d;
        mask_q  <= mask_d;
      end
      if (take_o) begin
        out_valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      issued_q <= issued_d;
      handed_q <= handed_d;
    end
  end

  // Gate mode and count registers already hold the post-event values.
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.issued_number   = issued_q;
  assign rsp_o.deferred_events = handed_q;
  assign rsp_o.gate_state      = mode_q;
  assign rsp_o.publisher_count = count_q;

endmodule

/* sv/publisher_quiesce_gate.sv */
// Top level of the publisher quiesce gate: APB registers, input register, engine.
// Depends on pqg_pkg, pqg_req_if, pqg_rsp_if and the pqg_* modules.
//
// The gate takes one event transfer per clock cycle while results are taken
// and returns exactly one result for each. An accepted request waits in the
// input register, then the event is evaluated and the gate state is updated
// as it moves into the result register. A stalled result holds the pipeline;
// the input register still accepts one more transfer behind it. Write
// gate_owner (offset 0x0) and deferrable_events (offset 0x8) only while no
// event is in flight; with gate_owner at zero every event answers invalid.
module publisher_quiesce_gate
  import pqg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  pqg_req_if.sink          req_i,
  pqg_rsp_if.source        rsp_o
);

  cfg_t cfg;
  logic stage_valid;
  req_t stage_req;
  logic take;

  pqg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pqg_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .take_i  (take),
    .valid_o (stage_valid),
    .req_o   (stage_req)
  );

  pqg_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (stage_valid),
    .req_i   (stage_req),
    .take_o  (take),
    .rsp_o   (rsp_o)
  );

endmodule
